// ===== sv/stocc_pkg.sv =====
package stocc_pkg;

   // Widths of the request and response fields.
   localparam int CMD_W   = 3;
   localparam int ROW_W   = 5;
   localparam int COL_W   = 5;
   localparam int TIME_W  = 6;
   localparam int CNT_W   = 8;
   localparam int FOUND_W = 7;

   // Defaults of the top level parameters.
   localparam int DEF_GRID_ROWS    = 32;
   localparam int DEF_GRID_COLS    = 32;
   localparam int DEF_TIME_HORIZON = 64;
   localparam int DEF_COUNT_BITS   = 8;

   // Entries of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // Command codes as they arrive on the request channel.
   localparam logic [CMD_W-1:0] CMD_ADD       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_COUNT     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FIRST     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_INTERVALS = 3'd4;

   // Time value that reports "no time".
   localparam logic signed [FOUND_W-1:0] NO_TIME = '1;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_REMOVE,
      OP_COUNT,
      OP_FIRST,
      OP_INTERVALS
   } op_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_EVAL,
      S_EMIT_RUN,
      S_EMIT_GAP,
      S_END_RUN,
      S_END_GAP
   } state_type;

   // A classified request as it waits in the queue.
   typedef struct packed {
      op_type              kind;
      logic [ROW_W-1:0]    cell_row;
      logic [COL_W-1:0]    cell_col;
      logic [TIME_W-1:0]   time_step;
      logic [TIME_W-1:0]   window_end;
      logic                binary_mode;
      logic                cell_ok;
      logic                window_ok;
   } entry_type;

endpackage

// ===== sv/stocc_ifs.sv =====
interface stocc_req_if;
   import stocc_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [ROW_W-1:0]  cell_row;
   logic [COL_W-1:0]  cell_col;
   logic [TIME_W-1:0] time_step;
   logic [TIME_W-1:0] window_end;
   logic              binary_mode;

   modport source (
      output valid, command, cell_row, cell_col, time_step, window_end, binary_mode,
      input  ready
   );
   modport sink (
      input  valid, command, cell_row, cell_col, time_step, window_end, binary_mode,
      output ready
   );
endinterface

interface stocc_rsp_if;
   import stocc_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [CNT_W-1:0]           agent_count;
   logic signed [FOUND_W-1:0]  found_time;
   logic                       last_result;

   modport source (
      output valid, agent_count, found_time, last_result,
      input  ready
   );
   modport sink (
      input  valid, agent_count, found_time, last_result,
      output ready
   );
endinterface

// ===== sv/stocc_front.sv =====
module stocc_front #(
   parameter int GRID_ROWS = stocc_pkg::DEF_GRID_ROWS,
   parameter int GRID_COLS = stocc_pkg::DEF_GRID_COLS
) (
   stocc_req_if.sink              req_chan,
   input  logic                   clearing,
   input  logic                   q_ready,
   output logic                   q_push,
   output stocc_pkg::entry_type   q_data
);
   import stocc_pkg::*;

   logic   known;
   logic   drop_empty;
   op_type kind;

   // Requests are held off only while the store is being cleared or the queue is full.
   assign req_chan.ready = q_ready && !clearing;

   always_comb begin
      known = 1'b1;
      kind  = OP_ADD;
      case (req_chan.command)
         CMD_ADD:       kind = OP_ADD;
         CMD_REMOVE:    kind = OP_REMOVE;
         CMD_COUNT:     kind = OP_COUNT;
         CMD_FIRST:     kind = OP_FIRST;
         CMD_INTERVALS: kind = OP_INTERVALS;
         default:       known = 1'b0;
      endcase
   end

   assign q_data.kind        = kind;
   assign q_data.cell_row    = req_chan.cell_row;
   assign q_data.cell_col    = req_chan.cell_col;
   assign q_data.time_step   = req_chan.time_step;
   assign q_data.window_end  = req_chan.window_end;
   assign q_data.binary_mode = req_chan.binary_mode;
   assign q_data.cell_ok     = (9'(req_chan.cell_row) < 9'(GRID_ROWS)) &&
                               (9'(req_chan.cell_col) < 9'(GRID_COLS));
   assign q_data.window_ok   = req_chan.time_step <= req_chan.window_end;

   // An interval walk over an empty window has nothing to report, so it is dropped here.
   assign drop_empty = (kind == OP_INTERVALS) && !q_data.window_ok;
   assign q_push     = req_chan.valid && req_chan.ready && known && !drop_empty;

endmodule

// ===== sv/stocc_fifo.sv =====
module stocc_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  stocc_pkg::entry_type  push_data,
   output logic                  push_ready,
   input  logic                  pop,
   output logic                  pop_valid,
   output stocc_pkg::entry_type  pop_data
);
   import stocc_pkg::*;

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   entry_type           slot_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = count_ff != CntW'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/stocc_back.sv =====
module stocc_back #(
   parameter int GRID_ROWS    = stocc_pkg::DEF_GRID_ROWS,
   parameter int GRID_COLS    = stocc_pkg::DEF_GRID_COLS,
   parameter int TIME_HORIZON = stocc_pkg::DEF_TIME_HORIZON,
   parameter int COUNT_BITS   = stocc_pkg::DEF_COUNT_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  stocc_pkg::entry_type  q_data,
   output logic                  q_pop,
   output logic                  clearing,
   stocc_rsp_if.source           rsp_chan
);
   import stocc_pkg::*;

   localparam int RowBits  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
   localparam int ColBits  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
   localparam int TimeBits = $clog2(TIME_HORIZON);
   localparam int AddrBits = RowBits + ColBits + TimeBits;
   localparam int Depth    = 1 << AddrBits;
   localparam logic [COUNT_BITS-1:0] CountMax = '1;

   logic [COUNT_BITS-1:0]      mem [Depth];
   logic [COUNT_BITS-1:0]      rd_data_ff;

   state_type                  state_ff, state_in;
   entry_type                  cur_ff, cur_in;
   logic [TIME_W-1:0]          t_ff, t_in;
   logic [TIME_W:0]            nxt_ff, nxt_in;
   logic [TIME_W-1:0]          run_begin_ff, run_begin_in;
   logic [COUNT_BITS-1:0]      run_count_ff, run_count_in;
   logic                       run_open_ff, run_open_in;
   logic [AddrBits-1:0]        clr_addr_ff, clr_addr_in;

   logic                       rsp_valid_ff;
   logic [CNT_W-1:0]           rsp_count_ff;
   logic signed [FOUND_W-1:0]  rsp_time_ff;
   logic                       rsp_last_ff;

   logic                       out_free;
   logic                       t_in_range;
   logic [AddrBits-1:0]        addr;
   logic [COUNT_BITS-1:0]      cnt_now;
   logic [COUNT_BITS-1:0]      upd;
   logic                       nonzero, gap, newrun, at_stop, gap_left;

   logic                       mem_re, mem_we;
   logic [AddrBits-1:0]        mem_waddr;
   logic [COUNT_BITS-1:0]      mem_wdata;
   logic                       emit;
   logic [CNT_W-1:0]           emit_count;
   logic signed [FOUND_W-1:0]  emit_time;
   logic                       emit_last;

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign t_in_range = cur_ff.cell_ok && ({1'b0, t_ff} < (TIME_W + 1)'(TIME_HORIZON));
   assign addr       = {RowBits'(cur_ff.cell_row), ColBits'(cur_ff.cell_col), TimeBits'(t_ff)};
   assign cnt_now    = t_in_range ? rd_data_ff : '0;
   assign nonzero    = cnt_now != '0;
   assign gap        = {1'b0, t_ff} > nxt_ff;
   assign newrun     = gap || !run_open_ff || (!cur_ff.binary_mode && cnt_now != run_count_ff);
   assign at_stop    = t_ff == cur_ff.window_end;
   assign gap_left   = nxt_ff <= {1'b0, cur_ff.window_end};
   assign clearing   = state_ff == S_CLEAR;

   always_comb begin
      if (cur_ff.kind == OP_ADD) begin
         upd = (cnt_now == CountMax) ? cnt_now : cnt_now + 1'b1;
      end else begin
         upd = (cnt_now == '0) ? cnt_now : cnt_now - 1'b1;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_addr_ff == '1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (q_valid) state_in = S_READ;
         end
         S_READ: state_in = S_EVAL;
         S_EVAL: begin
            case (cur_ff.kind)
               OP_ADD, OP_REMOVE, OP_COUNT: begin
                  if (out_free) state_in = S_IDLE;
               end
               OP_FIRST: begin
                  if ((nonzero && cur_ff.window_ok) || at_stop || !cur_ff.window_ok) begin
                     if (out_free) state_in = S_IDLE;
                  end else begin
                     state_in = S_READ;
                  end
               end
               OP_INTERVALS: begin
                  if (nonzero && newrun && run_open_ff) begin
                     state_in = S_EMIT_RUN;
                  end else if (nonzero && newrun && gap) begin
                     state_in = S_EMIT_GAP;
                  end else begin
                     state_in = at_stop ? S_END_RUN : S_READ;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_EMIT_RUN, S_EMIT_GAP: begin
            if (out_free) state_in = S_EVAL;
         end
         S_END_RUN: begin
            if (!run_open_ff || out_free) state_in = S_END_GAP;
         end
         S_END_GAP: begin
            if (!gap_left || out_free) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // Datapath controls and results.
   always_comb begin
      q_pop        = 1'b0;
      mem_re       = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = addr;
      mem_wdata    = upd;
      emit         = 1'b0;
      emit_count   = '0;
      emit_time    = NO_TIME;
      emit_last    = 1'b0;
      cur_in       = cur_ff;
      t_in         = t_ff;
      nxt_in       = nxt_ff;
      run_begin_in = run_begin_ff;
      run_count_in = run_count_ff;
      run_open_in  = run_open_ff;
      clr_addr_in  = clr_addr_ff;
      case (state_ff)
         S_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         S_IDLE: begin
            if (q_valid) begin
               q_pop       = 1'b1;
               cur_in      = q_data;
               t_in        = q_data.time_step;
               nxt_in      = {1'b0, q_data.time_step};
               run_open_in = 1'b0;
            end
         end
         S_READ: mem_re = t_in_range;
         S_EVAL: begin
            case (cur_ff.kind)
               OP_ADD, OP_REMOVE: begin
                  if (out_free) begin
                     mem_we     = t_in_range;
                     emit       = 1'b1;
                     emit_count = t_in_range ? CNT_W'(upd) : '0;
                     emit_last  = 1'b1;
                  end
               end
               OP_COUNT: begin
                  if (out_free) begin
                     emit       = 1'b1;
                     emit_count = CNT_W'(cnt_now);
                     emit_last  = 1'b1;
                  end
               end
               OP_FIRST: begin
                  if (nonzero && cur_ff.window_ok) begin
                     emit      = out_free;
                     emit_time = signed'({1'b0, t_ff});
                     emit_last = 1'b1;
                  end else if (at_stop || !cur_ff.window_ok) begin
                     emit      = out_free;
                     emit_last = 1'b1;
                  end else begin
                     t_in = t_ff + 1'b1;
                  end
               end
               OP_INTERVALS: begin
                  if (!nonzero) begin
                     if (!at_stop) t_in = t_ff + 1'b1;
                  end else if (!(newrun && (run_open_ff || gap))) begin
                     if (newrun) begin
                        run_begin_in = t_ff;
                        run_count_in = cnt_now;
                        run_open_in  = 1'b1;
                     end
                     nxt_in = {1'b0, t_ff} + 1'b1;
                     if (!at_stop) t_in = t_ff + 1'b1;
                  end
               end
               default: ;
            endcase
         end
         S_EMIT_RUN: begin
            if (out_free) begin
               emit        = 1'b1;
               emit_count  = CNT_W'(run_count_ff);
               emit_time   = signed'({1'b0, run_begin_ff});
               run_open_in = 1'b0;
            end
         end
         S_EMIT_GAP: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_time = signed'(nxt_ff);
               nxt_in    = {1'b0, t_ff};
            end
         end
         S_END_RUN: begin
            if (run_open_ff && out_free) begin
               emit        = 1'b1;
               emit_count  = CNT_W'(run_count_ff);
               emit_time   = signed'({1'b0, run_begin_ff});
               emit_last   = !gap_left;
               run_open_in = 1'b0;
            end
         end
         S_END_GAP: begin
            if (gap_left && out_free) begin
               emit      = 1'b1;
               emit_time = signed'(nxt_ff);
               emit_last = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         run_open_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         run_open_ff <= run_open_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      t_ff         <= t_in;
      nxt_ff       <= nxt_in;
      run_begin_ff <= run_begin_in;
      run_count_ff <= run_count_in;
      if (emit) begin
         rsp_count_ff <= emit_count;
         rsp_time_ff  <= emit_time;
         rsp_last_ff  <= emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.agent_count = rsp_count_ff;
   assign rsp_chan.found_time  = rsp_time_ff;
   assign rsp_chan.last_result = rsp_last_ff;

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_CLEAR || state_ff == S_EVAL))
      else $error("store written outside clearing or update");

   a_run_open: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT_RUN) |-> run_open_ff)
      else $error("closing a run that is not open");

   a_gap_exists: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT_GAP) |-> (nxt_ff < {1'b0, t_ff}))
      else $error("gap emitted without a gap");

   a_scan_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL && cur_ff.kind == OP_INTERVALS) |-> (t_ff <= cur_ff.window_end))
      else $error("interval walk beyond the window end");

endmodule

// ===== sv/space_time_occupancy_counter_unit.sv =====
// Space-time occupancy counter: an agent count for every grid cell and time step.
// Requests arrive on req_chan (valid/ready); one or more responses leave on
// rsp_chan (valid/ready), the final response of each request marked by last_result.
// Add and remove change one counter (add saturates, remove stops at zero), count
// reads one, first conflict finds the earliest occupied time in a window, and the
// interval walk reports the runs and gaps of a window in time order.
// The sequencer pops a request in its idle state and finishes it before it pops
// the next; the queue takes further requests meanwhile. Every time step is a read
// of the store into a register followed by an evaluation; first conflict repeats
// the two per time step scanned, and the interval walk adds an emit state per
// response that closes a run or a gap inside the window and S_END_RUN, S_END_GAP.
// At reset the store is cleared one entry a cycle, all 2^(row bits + column bits +
// time bits) entries (65536 at the default sizes); req_chan.ready stays low until
// the pass ends. A stalled receiver holds the response register, the back end
// waits on it, and the two-entry request queue then fills before ready drops.
module space_time_occupancy_counter_unit #(
   parameter int GRID_ROWS    = stocc_pkg::DEF_GRID_ROWS,
   parameter int GRID_COLS    = stocc_pkg::DEF_GRID_COLS,
   parameter int TIME_HORIZON = stocc_pkg::DEF_TIME_HORIZON,
   parameter int COUNT_BITS   = stocc_pkg::DEF_COUNT_BITS
) (
   input  logic         clock,
   input  logic         reset,
   stocc_req_if.sink    req_chan,
   stocc_rsp_if.source  rsp_chan
);
   import stocc_pkg::*;

   // Classified requests between the front end and the sequencer.
   entry_type push_data;
   entry_type pop_data;
   logic      push;
   logic      push_ready;
   logic      pop;
   logic      pop_valid;
   logic      clearing;

   // The front end decodes the command and checks the cell and window bounds;
   // commands that produce nothing are accepted and dropped here.
   stocc_front #(
      .GRID_ROWS (GRID_ROWS),
      .GRID_COLS (GRID_COLS)
   ) u_front (
      .req_chan (req_chan),
      .clearing (clearing),
      .q_ready  (push_ready),
      .q_push   (push),
      .q_data   (push_data)
   );

   // The queue lets the front end take requests while the sequencer is busy.
   stocc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   // The sequencer owns the count store and the response register.
   stocc_back #(
      .GRID_ROWS    (GRID_ROWS),
      .GRID_COLS    (GRID_COLS),
      .TIME_HORIZON (TIME_HORIZON),
      .COUNT_BITS   (COUNT_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (pop_valid),
      .q_data   (pop_data),
      .q_pop    (pop),
      .clearing (clearing),
      .rsp_chan (rsp_chan)
   );

endmodule
